/* src/bdqs_pkg.sv */
package bdqs_pkg;

    // Store geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int ACT_W  = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 5;
    localparam int STAT_W = 2;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DROP_FRONT = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DROP_BACK  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SEARCH     = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  occupancy;
    } t_result;

    // Microprogram addresses
    typedef enum logic [3:0] {
        S_IDLE,
        S_PF_CHK,
        S_PF_DO,
        S_PB_CHK,
        S_PB_DO,
        S_DF_CHK,
        S_DF_DO,
        S_DB_CHK,
        S_DB_DO,
        S_REJECT,
        S_IGNORE,
        S_SRCH_INIT,
        S_SRCH_SCAN,
        S_EMIT
    } t_step;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_DROP_FRONT,
        OP_DROP_BACK,
        OP_SET_FULL,
        OP_SET_EMPTY,
        OP_SCAN_INIT,
        OP_SCAN_STEP,
        OP_EMIT
    } t_uop;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_START,
        C_FULL,
        C_EMPTY,
        C_SCAN_END
    } t_cond;

    // One control word: op, jump condition, jump target, and whether a
    // not-taken jump holds the step instead of falling through.
    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_step target;
        logic  hold;
    } t_ctrl;

    // Control store
    function automatic t_ctrl ucode(input t_step pc);
        t_ctrl w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE, hold: 1'b0};
        case (pc)
            S_IDLE:      w = '{op: OP_ACCEPT,     cond: C_START,    target: S_IDLE,   hold: 1'b1};
            S_PF_CHK:    w = '{op: OP_NOP,        cond: C_FULL,     target: S_REJECT, hold: 1'b0};
            S_PF_DO:     w = '{op: OP_PUSH_FRONT, cond: C_ALWAYS,   target: S_EMIT,   hold: 1'b0};
            S_PB_CHK:    w = '{op: OP_NOP,        cond: C_FULL,     target: S_REJECT, hold: 1'b0};
            S_PB_DO:     w = '{op: OP_PUSH_BACK,  cond: C_ALWAYS,   target: S_EMIT,   hold: 1'b0};
            S_DF_CHK:    w = '{op: OP_NOP,        cond: C_EMPTY,    target: S_IGNORE, hold: 1'b0};
            S_DF_DO:     w = '{op: OP_DROP_FRONT, cond: C_ALWAYS,   target: S_EMIT,   hold: 1'b0};
            S_DB_CHK:    w = '{op: OP_NOP,        cond: C_EMPTY,    target: S_IGNORE, hold: 1'b0};
            S_DB_DO:     w = '{op: OP_DROP_BACK,  cond: C_ALWAYS,   target: S_EMIT,   hold: 1'b0};
            S_REJECT:    w = '{op: OP_SET_FULL,   cond: C_ALWAYS,   target: S_EMIT,   hold: 1'b0};
            S_IGNORE:    w = '{op: OP_SET_EMPTY,  cond: C_ALWAYS,   target: S_EMIT,   hold: 1'b0};
            S_SRCH_INIT: w = '{op: OP_SCAN_INIT,  cond: C_EMPTY,    target: S_EMIT,   hold: 1'b0};
            S_SRCH_SCAN: w = '{op: OP_SCAN_STEP,  cond: C_SCAN_END, target: S_EMIT,   hold: 1'b1};
            S_EMIT:      w = '{op: OP_EMIT,       cond: C_ALWAYS,   target: S_IDLE,   hold: 1'b0};
            default:     w = '{op: OP_NOP,        cond: C_ALWAYS,   target: S_IDLE,   hold: 1'b0};
        endcase
        return w;
    endfunction

endpackage

/* src/bounded_deque_with_search_top.sv */
// Bounded deque of signed 32-bit values with key search, run by a small
// microprogram. Raise start with an item while busy is low; busy stays high
// until the cycle after the single result, which appears on o_result for
// exactly one cycle with o_valid high and cannot be held off. An unknown
// action goes straight to the result; a push or drop checks for full or
// empty, then does the operation or flags the status; a search skips the
// scan when empty, else scans from the front until a hit or the last entry,
// reading one store entry per cycle through the single read port. The store
// holds CAPACITY (16) entries and needs no clearing after reset.
module bounded_deque_with_search_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  bdqs_pkg::t_in_item i_item,
    output logic               o_valid,
    output bdqs_pkg::t_result  o_result
);
    import bdqs_pkg::*;

    // Store slot for a logical offset from a given front slot
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] ofs);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
        if (sum >= (CNT_W+1)'(CAPACITY)) begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Entry point of each action's routine
    function automatic t_step dispatch(input logic [ACT_W-1:0] act);
        t_step s;
        case (act)
            ACT_PUSH_FRONT: s = S_PF_CHK;
            ACT_PUSH_BACK:  s = S_PB_CHK;
            ACT_DROP_FRONT: s = S_DF_CHK;
            ACT_DROP_BACK:  s = S_DB_CHK;
            ACT_SEARCH:     s = S_SRCH_INIT;
            default:        s = S_EMIT;
        endcase
        return s;
    endfunction

    t_step r_pc, n_pc;
    t_ctrl ctrl;

    logic [VAL_W-1:0]  r_key, n_key;
    logic [IDX_W-1:0]  r_front, n_front;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [POS_W-1:0]  r_position, n_position;
    logic [STAT_W-1:0] r_status, n_status;

    // Store and its write and read ports
    logic [VAL_W-1:0] r_mem [CAPACITY];
    logic [VAL_W-1:0] r_rdata;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;

    logic is_full, is_empty, hit, last, taken;

    assign ctrl     = ucode(r_pc);
    assign is_full  = (r_count == CNT_W'(CAPACITY));
    assign is_empty = (r_count == '0);
    assign hit      = (r_rdata == r_key);
    assign last     = ((r_idx + CNT_W'(1)) == r_count);

    // Jump condition
    always_comb begin
        case (ctrl.cond)
            C_NEVER:    taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_START:    taken = start;
            C_FULL:     taken = is_full;
            C_EMPTY:    taken = is_empty;
            C_SCAN_END: taken = hit || last;
            default:    taken = 1'b0;
        endcase
    end

    // Sequencer: step counter next value
    always_comb begin
        if (taken) begin
            n_pc = (ctrl.cond == C_START) ? dispatch(i_item.action) : ctrl.target;
        end else if (ctrl.hold) begin
            n_pc = r_pc;
        end else begin
            n_pc = t_step'(r_pc + 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Datapath driven by the control word
    always_comb begin
        n_key      = r_key;
        n_front    = r_front;
        n_count    = r_count;
        n_idx      = r_idx;
        n_position = r_position;
        n_status   = r_status;
        wr_en      = 1'b0;
        wr_addr    = slot_of(r_front, r_count);
        rd_addr    = slot_of(r_front, r_idx + CNT_W'(1));
        case (ctrl.op)
            OP_ACCEPT: begin
                if (start) begin
                    n_key      = i_item.value;
                    n_position = '0;
                    n_status   = ST_DONE;
                end
            end
            OP_PUSH_FRONT: begin
                n_front = (r_front == '0) ? IDX_W'(CAPACITY - 1) : r_front - IDX_W'(1);
                wr_en   = 1'b1;
                wr_addr = n_front;
                n_count = r_count + CNT_W'(1);
            end
            OP_PUSH_BACK: begin
                wr_en   = 1'b1;
                n_count = r_count + CNT_W'(1);
            end
            OP_DROP_FRONT: begin
                n_front = slot_of(r_front, CNT_W'(1));
                n_count = r_count - CNT_W'(1);
            end
            OP_DROP_BACK: begin
                n_count = r_count - CNT_W'(1);
            end
            OP_SET_FULL:  n_status = ST_FULL;
            OP_SET_EMPTY: n_status = ST_EMPTY;
            OP_SCAN_INIT: begin
                n_idx   = '0;
                rd_addr = r_front;
            end
            OP_SCAN_STEP: begin
                // rdata holds entry r_idx; fetch the next one meanwhile
                if (hit) begin
                    n_position = POS_W'(r_idx + CNT_W'(1));
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_position <= n_position;
        r_status   <= n_status;
    end

    // Entry store, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_key;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Outputs
    assign busy               = (r_pc != S_IDLE);
    assign o_valid            = (ctrl.op == OP_EMIT);
    assign o_result.position  = r_position;
    assign o_result.status    = r_status;
    assign o_result.occupancy = POS_W'(r_count);

endmodule

/* src/bdqs_chk.sv */
module bdqs_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input bdqs_pkg::t_in_item i_item,
    input logic               o_valid,
    input bdqs_pkg::t_result  o_result
);
    import bdqs_pkg::*;

    // An accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // Result only while busy, and the block is idle right after it
    a_result_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy ##1 !busy)
        else $error("busy not released after result");

    // Result strobe lasts one cycle
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // Rejected or ignored transactions report no position
    a_flag_no_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.status != ST_DONE) |-> (o_result.position == '0))
        else $error("position set on flagged result");

    // Occupancy bounded, and a match lies within it
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.occupancy <= POS_W'(CAPACITY))
                    && (o_result.position <= o_result.occupancy))
        else $error("occupancy or position out of range");

endmodule

bind bounded_deque_with_search_top bdqs_chk u_bdqs_chk (.*);

/* sim/tb_bounded_deque_with_search_top.sv */
module tb_bounded_deque_with_search_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bdqs_pkg::*;

    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_in_item i_item  = '0;
    logic     busy;
    logic     o_valid;
    t_result  o_result;

    bounded_deque_with_search_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #1 i_clk = ~i_clk;

    // Stimulus waiting to be driven, and results the deque owes us
    t_in_item pending_items[$];
    t_result  expected_results[$];

    // Shadow copy of the deque contents
    logic [VAL_W-1:0] shadow_store[CAPACITY];
    int               shadow_front = 0;
    int               shadow_count = 0;

    // Occupancy as the stimulus generator sees it, to size sequences
    int gen_occ   = 0;
    int gen_items = 0;

    int fail_count     = 0;
    int accepted_count = 0;
    int cycle_count    = 0;
    int sender_idle_pct;
    bit item_taken     = 1'b0;

    // Apply one action to the shadow deque and return the result it owes
    function automatic t_result apply_deque_action(t_in_item it);
        t_result r;
        int      k;
        bit      found;
        r     = '0;
        found = 1'b0;
        case (it.action)
            ACT_PUSH_FRONT: begin
                if (shadow_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_front = (shadow_front == 0) ? CAPACITY - 1 : shadow_front - 1;
                    shadow_store[shadow_front] = it.value;
                    shadow_count++;
                end
            end
            ACT_PUSH_BACK: begin
                if (shadow_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_store[(shadow_front + shadow_count) % CAPACITY] = it.value;
                    shadow_count++;
                end
            end
            ACT_DROP_FRONT: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    shadow_front = (shadow_front + 1) % CAPACITY;
                    shadow_count--;
                end
            end
            ACT_DROP_BACK: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    shadow_count--;
                end
            end
            ACT_SEARCH: begin
                // first match counted from the front, 1-based
                for (k = 0; k < shadow_count; k++) begin
                    if (!found && shadow_store[(shadow_front + k) % CAPACITY] == it.value) begin
                        r.position = POS_W'(k + 1);
                        found      = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        r.occupancy = POS_W'(shadow_count);
        return r;
    endfunction

    // Idle rate of the sender by phase of the run
    always_comb begin
        if (accepted_count < 270)
            sender_idle_pct = 31;
        else if (accepted_count < 540)
            sender_idle_pct = 77;
        else
            sender_idle_pct = 0;
    end

    // Driver: present the next item at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || item_taken) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                i_item <= pending_items.pop_front();
                start  <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check results, record accepted transactions, watch the clock
    always @(posedge i_clk) begin
        t_result exp_r;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: position %0d status %0d occupancy %0d",
                       o_result.position, o_result.status, o_result.occupancy);
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_result.position !== exp_r.position) begin
                    $error("position: expected %0d, got %0d", exp_r.position, o_result.position);
                    fail_count++;
                end
                if (o_result.status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_result.status);
                    fail_count++;
                end
                if (o_result.occupancy !== exp_r.occupancy) begin
                    $error("occupancy: expected %0d, got %0d",
                           exp_r.occupancy, o_result.occupancy);
                    fail_count++;
                end
            end
        end
        item_taken = i_rst_n && start && !busy;
        if (item_taken) begin
            expected_results.push_back(apply_deque_action(i_item));
            accepted_count++;
        end
    end

    task automatic add_item(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val);
        t_in_item it;
        it.action = act;
        it.value  = val;
        pending_items.push_back(it);
        gen_items++;
        if ((act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) && gen_occ < CAPACITY)
            gen_occ++;
        else if ((act == ACT_DROP_FRONT || act == ACT_DROP_BACK) && gen_occ > 0)
            gen_occ--;
    endtask

    // Mostly a small pool so that searches hit and duplicates occur
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            5: return 32'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ACT_W-1:0] pick_action();
        int r;
        r = $urandom_range(0, 19);
        if (r < 4)  return ACT_PUSH_FRONT;
        if (r < 8)  return ACT_PUSH_BACK;
        if (r < 11) return ACT_DROP_FRONT;
        if (r < 14) return ACT_DROP_BACK;
        if (r < 19) return ACT_SEARCH;
        return ACT_SEARCH + ACT_W'($urandom_range(1, 3));
    endfunction

    initial begin
        int n;
        int k;

        // Directed: empty cases, unknown actions, extreme values at both ends
        add_item(ACT_DROP_FRONT, 32'h0);
        add_item(ACT_DROP_BACK, 32'h0);
        add_item(ACT_SEARCH, 32'h0);
        for (k = 1; k <= 3; k++)
            add_item(ACT_SEARCH + ACT_W'(k), 32'hFFFF_FFFF);
        add_item(ACT_PUSH_BACK, 32'h7FFF_FFFF);
        add_item(ACT_PUSH_FRONT, 32'h8000_0000);
        add_item(ACT_PUSH_BACK, 32'h0000_0000);
        add_item(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
        add_item(ACT_SEARCH, 32'hFFFF_FFFF);
        add_item(ACT_SEARCH, 32'h0000_0000);
        add_item(ACT_SEARCH, 32'h8000_0000);
        add_item(ACT_SEARCH, 32'h1234_5678);
        add_item(ACT_DROP_FRONT, 32'hFFFF_FFFF);
        add_item(ACT_DROP_BACK, 32'h0);
        add_item(ACT_SEARCH, 32'h7FFF_FFFF);
        add_item(ACT_SEARCH, 32'h8000_0000);

        // Random: fill to full and past, drain to empty and past, mixed traffic
        while (gen_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: begin
                    n = CAPACITY - gen_occ + $urandom_range(1, 3);
                    for (k = 0; k < n; k++)
                        add_item($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
                                 pick_value());
                    for (k = 0; k < 3; k++)
                        add_item(ACT_SEARCH, pick_value());
                end
                6, 7, 8, 9, 10: begin
                    n = gen_occ + $urandom_range(1, 2);
                    for (k = 0; k < n; k++)
                        add_item($urandom_range(0, 1) ? ACT_DROP_FRONT : ACT_DROP_BACK,
                                 $urandom);
                end
                default: begin
                    for (k = 0; k < 12; k++)
                        add_item(pick_action(), pick_value());
                end
            endcase
        end

        // Reset, released at a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every item to be taken and answered
        @(negedge i_clk);
        while (pending_items.size() > 0 || start || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
